// ----- rtl/pbs_pkg.sv -----
// ----------------------------------------------------------------------------
// pbs_pkg
// Shared constants and types for the premultiplied bilinear sampler.
// ----------------------------------------------------------------------------
package pbs_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int PIX_W         = 32;
    localparam int CHAN_W        = 8;
    localparam int FRAC_IN_W     = 8;
    localparam int NUM_CORNERS   = 4;
    localparam int NUM_COLORS    = 3;
    localparam int ALPHA_LSB     = 24;
    localparam int QUOT_BITS     = 8;

    // corner order: top left, top right, bottom left, bottom right
    localparam int CORNER_TL = 0;
    localparam int CORNER_TR = 1;
    localparam int CORNER_BL = 2;
    localparam int CORNER_BR = 3;

    // red 7:0, green 15:8, blue 23:16, alpha 31:24
    typedef logic [PIX_W-1:0]     pixel_t;
    typedef logic [CHAN_W-1:0]    chan_t;
    typedef logic [QUOT_BITS-1:0] quot_t;

endpackage

// ----- rtl/pbs_weight.sv -----
// ----------------------------------------------------------------------------
// pbs_weight
// Two stages: bilinear corner weights, then alpha times weight per corner.
// ----------------------------------------------------------------------------
module pbs_weight #(
    parameter int FRAC_BITS = pbs_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic [1:0]                      en,
    input  pbs_pkg::pixel_t                 pix_in [pbs_pkg::NUM_CORNERS],
    input  logic [pbs_pkg::FRAC_IN_W-1:0]   frac_x,
    input  logic [pbs_pkg::FRAC_IN_W-1:0]   frac_y,
    output logic [2*FRAC_BITS+7:0]          aw_out [pbs_pkg::NUM_CORNERS],
    output pbs_pkg::pixel_t                 pix_out [pbs_pkg::NUM_CORNERS]
);
    import pbs_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int WW = 2*F + 1;
    localparam int AW = 2*F + 8;
    localparam logic [F:0] ONE = (F+1)'(1) << F;

    logic [31:0]     fx_ext;
    logic [31:0]     fy_ext;
    logic [F:0]      wx [2];
    logic [F:0]      wy [2];
    logic [2*F+1:0]  wprod [NUM_CORNERS];
    logic [WW-1:0]   w_next [NUM_CORNERS];
    logic [AW:0]     awprod [NUM_CORNERS];

    logic [WW-1:0]   w_reg [NUM_CORNERS];
    pixel_t          pix0_reg [NUM_CORNERS];
    logic [AW-1:0]   aw_reg [NUM_CORNERS];
    pixel_t          pix1_reg [NUM_CORNERS];

    // only the low FRAC_BITS of the fraction are used
    assign fx_ext = {{(32-FRAC_IN_W){1'b0}}, frac_x};
    assign fy_ext = {{(32-FRAC_IN_W){1'b0}}, frac_y};

    always_comb
    begin
        wx[1] = {1'b0, fx_ext[F-1:0]};
        wy[1] = {1'b0, fy_ext[F-1:0]};
        wx[0] = ONE - wx[1];
        wy[0] = ONE - wy[1];
        wprod[CORNER_TL] = wx[0] * wy[0];
        wprod[CORNER_TR] = wx[1] * wy[0];
        wprod[CORNER_BL] = wx[0] * wy[1];
        wprod[CORNER_BR] = wx[1] * wy[1];
        for (int k = 0; k < NUM_CORNERS; k++)
        begin
            w_next[k] = wprod[k][WW-1:0];
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_CORNERS; k++)
        begin
            awprod[k] = pix0_reg[k][ALPHA_LSB +: CHAN_W] * w_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            w_reg    <= w_next;
            pix0_reg <= pix_in;
        end
        if (en[1])
        begin
            for (int k = 0; k < NUM_CORNERS; k++)
            begin
                aw_reg[k] <= awprod[k][AW-1:0];
            end
            pix1_reg <= pix0_reg;
        end
    end

    assign aw_out  = aw_reg;
    assign pix_out = pix1_reg;

endmodule

// ----- rtl/pbs_accum.sv -----
// ----------------------------------------------------------------------------
// pbs_accum
// Two stages: weighted color products, then sums, dividend, divisor, alpha.
// ----------------------------------------------------------------------------
module pbs_accum #(
    parameter int FRAC_BITS = pbs_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic [1:0]                      en,
    input  logic [2*FRAC_BITS+7:0]          aw_in [pbs_pkg::NUM_CORNERS],
    input  pbs_pkg::pixel_t                 pix_in [pbs_pkg::NUM_CORNERS],
    output logic [2*FRAC_BITS+17:0]         rem_out [pbs_pkg::NUM_COLORS],
    output logic [2*FRAC_BITS+8:0]          div_out,
    output pbs_pkg::chan_t                  alpha_out
);
    import pbs_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int AW = 2*F + 8;
    localparam int NW = 2*F + 16;
    localparam int DW = NW + 2;
    localparam logic [AW:0] HALF = (AW+1)'(1) << (2*F - 1);

    logic [NW-1:0]   prod_next [NUM_COLORS][NUM_CORNERS];
    logic [AW+1:0]   asum_wide;
    logic [NW+1:0]   nsum [NUM_COLORS];
    logic [DW-1:0]   dvd_next [NUM_COLORS];
    logic [AW:0]     div_next;
    logic [AW:0]     alpha_wide;
    logic [AW-2*F:0] alpha_q;
    chan_t           alpha_next;

    logic [NW-1:0]   prod_reg [NUM_COLORS][NUM_CORNERS];
    logic [AW-1:0]   asum_reg;
    logic [DW-1:0]   dvd_reg [NUM_COLORS];
    logic [AW:0]     div_reg;
    chan_t           alpha_reg;

    always_comb
    begin
        asum_wide = '0;
        for (int k = 0; k < NUM_CORNERS; k++)
        begin
            asum_wide = asum_wide + (AW+2)'(aw_in[k]);
            for (int c = 0; c < NUM_COLORS; c++)
            begin
                prod_next[c][k] = pix_in[k][c*CHAN_W +: CHAN_W] * aw_in[k];
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < NUM_COLORS; c++)
        begin
            nsum[c] = '0;
            for (int k = 0; k < NUM_CORNERS; k++)
            begin
                nsum[c] = nsum[c] + (NW+2)'(prod_reg[c][k]);
            end
            // rounded quotient: (2N + A) / (2A)
            dvd_next[c] = {nsum[c][NW-1:0], 1'b0} + DW'(asum_reg);
        end
        // zero alpha sum: dividend is zero, any nonzero divisor yields zero
        if (asum_reg == '0)
            div_next = (AW+1)'(1);
        else
            div_next = {asum_reg, 1'b0};
        alpha_wide = (AW+1)'(asum_reg) + HALF;
        alpha_q    = alpha_wide[AW:2*F];
        if (alpha_q > (AW-2*F+1)'(255))
            alpha_next = 8'hFF;
        else
            alpha_next = alpha_q[CHAN_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            prod_reg <= prod_next;
            asum_reg <= asum_wide[AW-1:0];
        end
        if (en[1])
        begin
            dvd_reg   <= dvd_next;
            div_reg   <= div_next;
            alpha_reg <= alpha_next;
        end
    end

    assign rem_out   = dvd_reg;
    assign div_out   = div_reg;
    assign alpha_out = alpha_reg;

endmodule

// ----- rtl/pbs_div_step.sv -----
// ----------------------------------------------------------------------------
// pbs_div_step
// One restoring division stage: resolves quotient bit STEP for each color.
// ----------------------------------------------------------------------------
module pbs_div_step #(
    parameter int FRAC_BITS = pbs_pkg::FRAC_BITS_DEF,
    parameter int STEP      = pbs_pkg::QUOT_BITS - 1
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic [2*FRAC_BITS+17:0]         rem_in [pbs_pkg::NUM_COLORS],
    input  pbs_pkg::quot_t                  q_in [pbs_pkg::NUM_COLORS],
    input  logic [2*FRAC_BITS+8:0]          div_in,
    input  pbs_pkg::chan_t                  alpha_in,
    output logic [2*FRAC_BITS+17:0]         rem_out [pbs_pkg::NUM_COLORS],
    output pbs_pkg::quot_t                  q_out [pbs_pkg::NUM_COLORS],
    output logic [2*FRAC_BITS+8:0]          div_out,
    output pbs_pkg::chan_t                  alpha_out
);
    import pbs_pkg::*;

    localparam int DW = 2*FRAC_BITS + 18;

    logic [DW-1:0] shifted;
    logic [DW-1:0] rem_next [NUM_COLORS];
    quot_t         q_next [NUM_COLORS];

    logic [DW-1:0]             rem_reg [NUM_COLORS];
    quot_t                     q_reg [NUM_COLORS];
    logic [2*FRAC_BITS+8:0]    div_reg;
    chan_t                     alpha_reg;

    assign shifted = DW'(div_in) << STEP;

    always_comb
    begin
        for (int c = 0; c < NUM_COLORS; c++)
        begin
            q_next[c] = q_in[c];
            if (rem_in[c] >= shifted)
            begin
                rem_next[c]     = rem_in[c] - shifted;
                q_next[c][STEP] = 1'b1;
            end
            else
            begin
                rem_next[c] = rem_in[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg   <= rem_next;
            q_reg     <= q_next;
            div_reg   <= div_in;
            alpha_reg <= alpha_in;
        end
    end

    assign rem_out   = rem_reg;
    assign q_out     = q_reg;
    assign div_out   = div_reg;
    assign alpha_out = alpha_reg;

endmodule

// ----- rtl/premultiplied_bilinear_sampler_core.sv -----
// ----------------------------------------------------------------------------
// premultiplied_bilinear_sampler_core
// Alpha-weighted bilinear blend of four RGBA8 corners, unpremultiplied out.
// ----------------------------------------------------------------------------
// Accepts one request per clock while in_stall is low and returns one result
// per request, in order: two stages form the corner weights and alpha-weighted
// weights, two form the color products and sums, and eight run a restoring
// divider, one quotient bit per stage, for the rounded color quotients. Stalls
// propagate backward stage by stage, so empty stages keep filling while the
// output is held.
// ----------------------------------------------------------------------------
module premultiplied_bilinear_sampler_core #(
    parameter int FRAC_BITS = pbs_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [pbs_pkg::PIX_W-1:0]     corner_top_left,
    input  logic [pbs_pkg::PIX_W-1:0]     corner_top_right,
    input  logic [pbs_pkg::PIX_W-1:0]     corner_bottom_left,
    input  logic [pbs_pkg::PIX_W-1:0]     corner_bottom_right,
    input  logic [pbs_pkg::FRAC_IN_W-1:0] frac_x,
    input  logic [pbs_pkg::FRAC_IN_W-1:0] frac_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pbs_pkg::CHAN_W-1:0]    out_red,
    output logic [pbs_pkg::CHAN_W-1:0]    out_green,
    output logic [pbs_pkg::CHAN_W-1:0]    out_blue,
    output logic [pbs_pkg::CHAN_W-1:0]    out_alpha
);
    import pbs_pkg::*;

    localparam int F      = FRAC_BITS;
    localparam int AW     = 2*F + 8;
    localparam int DW     = 2*F + 18;
    localparam int NSTAGE = 4 + QUOT_BITS;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] en;

    pixel_t          pix_in [NUM_CORNERS];
    logic [AW-1:0]   aw_s [NUM_CORNERS];
    pixel_t          pix_s [NUM_CORNERS];

    logic [DW-1:0]   rem_s [QUOT_BITS+1][NUM_COLORS];
    quot_t           q_s [QUOT_BITS+1][NUM_COLORS];
    logic [AW:0]     div_s [QUOT_BITS+1];
    chan_t           alpha_s [QUOT_BITS+1];

    always_comb
    begin
        en[NSTAGE-1] = !valid_reg[NSTAGE-1] || !out_stall;
        for (int i = NSTAGE-2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTAGE; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign in_stall = !en[0];

    assign pix_in[CORNER_TL] = corner_top_left;
    assign pix_in[CORNER_TR] = corner_top_right;
    assign pix_in[CORNER_BL] = corner_bottom_left;
    assign pix_in[CORNER_BR] = corner_bottom_right;

    pbs_weight #(
        .FRAC_BITS (FRAC_BITS)
    ) u_weight (
        .clk     (clk),
        .en      (en[1:0]),
        .pix_in  (pix_in),
        .frac_x  (frac_x),
        .frac_y  (frac_y),
        .aw_out  (aw_s),
        .pix_out (pix_s)
    );

    pbs_accum #(
        .FRAC_BITS (FRAC_BITS)
    ) u_accum (
        .clk       (clk),
        .en        (en[3:2]),
        .aw_in     (aw_s),
        .pix_in    (pix_s),
        .rem_out   (rem_s[0]),
        .div_out   (div_s[0]),
        .alpha_out (alpha_s[0])
    );

    assign q_s[0] = '{default: '0};

    for (genvar j = 0; j < QUOT_BITS; j++)
    begin : g_div
        pbs_div_step #(
            .FRAC_BITS (FRAC_BITS),
            .STEP      (QUOT_BITS-1-j)
        ) u_step (
            .clk       (clk),
            .en        (en[4+j]),
            .rem_in    (rem_s[j]),
            .q_in      (q_s[j]),
            .div_in    (div_s[j]),
            .alpha_in  (alpha_s[j]),
            .rem_out   (rem_s[j+1]),
            .q_out     (q_s[j+1]),
            .div_out   (div_s[j+1]),
            .alpha_out (alpha_s[j+1])
        );
    end

    assign out_valid = valid_reg[NSTAGE-1];
    assign out_red   = q_s[QUOT_BITS][0];
    assign out_green = q_s[QUOT_BITS][1];
    assign out_blue  = q_s[QUOT_BITS][2];
    assign out_alpha = alpha_s[QUOT_BITS];

endmodule
